// ===== design/spo_pkg.sv =====
`timescale 1ns / 1ps
package spo_pkg;

  // defaults for the top level parameters
  localparam int SPO_NUM_CHANNELS = 16;
  localparam int SPO_PHASE_BITS   = 32;

  // field and port widths
  localparam int CH_W       = 4;
  localparam int MOD_W      = 17;
  localparam int WAVE_W     = 17;
  localparam int TDATA_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // serial arithmetic unit widths
  localparam int MUL_A_W = 64;
  localparam int MUL_B_W = 32;
  localparam int DIV_W   = 32;
  localparam int DEN_W   = 6;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LFO_ON = 3'd0,
    REG_COARSE = 3'd1,
    REG_FINE   = 3'd2,
    REG_PERIOD = 3'd3,
    REG_DETUNE = 3'd4
  } spo_reg_e;

  // register reset values
  localparam logic [23:0] PERIOD_RST = 24'd1431655;
  localparam logic [15:0] DETUNE_RST = 16'd41;

  // fixed-point constants
  localparam logic [24:0] C4_Q16    = 25'd17145893;
  localparam logic [31:0] ONE_Q30   = 32'd1073741824;
  localparam logic [31:0] E1        = 32'd744261118;
  localparam logic [31:0] E2        = 32'd257941248;
  localparam logic [31:0] E3        = 32'd59597083;
  localparam logic [31:0] E4        = 32'd10327387;
  localparam logic [31:0] E5        = 32'd1431681;
  localparam logic [51:0] INC_MIN   = 52'd4503599627;
  localparam logic [51:0] INC_MAX   = 52'd1576259869579674;
  localparam logic signed [33:0] SHAPE_OFS  = 34'sd1653562409;
  localparam logic signed [33:0] SHAPE_DROP = 34'sd107374182;
  localparam logic [15:0] FLIP_Q16  = 16'd11142;
  localparam logic signed [23:0] LFO_DROP = 24'sd327680;
  localparam logic signed [20:0] OUT_MAX  = 21'sd49152;

  // constant divisors
  localparam logic [DEN_W-1:0] DEN_COARSE = 6'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SLOT, ST_FINE, ST_COARSE, ST_EXP, ST_C4, ST_SHIFT,
    ST_SP, ST_RD, ST_UPD, ST_Y2, ST_CDIV, ST_CMUL, ST_OUT
  } spo_state_e;

  typedef struct packed {
    logic               done;
    logic               ovf;
    logic [MUL_A_W-1:0] prod;
  } spo_mul_rsp_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } spo_div_rsp_t;

  // taylor coefficients of 2^x, applied after the innermost one
  function automatic logic [31:0] exp_coef(input logic [2:0] k);
    logic [31:0] c;
    unique case (k)
      3'd0:    c = E4;
      3'd1:    c = E3;
      3'd2:    c = E2;
      3'd3:    c = E1;
      default: c = ONE_Q30;
    endcase
    return c;
  endfunction

  // cosine series divisors, innermost first
  function automatic logic [DEN_W-1:0] cos_den(input logic [1:0] j);
    logic [DEN_W-1:0] d;
    unique case (j)
      2'd0: d = 6'd56;
      2'd1: d = 6'd30;
      2'd2: d = 6'd12;
      2'd3: d = 6'd2;
    endcase
    return d;
  endfunction

endpackage

// ===== design/spo_ram.sv =====
`timescale 1ns / 1ps
module spo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/spo_mul.sv =====
`timescale 1ns / 1ps
module spo_mul import spo_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output spo_mul_rsp_t       rsp_o
);

  localparam int CNT_W = $clog2(MUL_B_W + 1);

  logic [MUL_A_W-1:0] a_q, acc_q, acc_d;
  logic [MUL_B_W-1:0] b_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               run_q, done_q, ovf_q, ovf_d;
  logic [MUL_A_W+1:0] nxt;

  // msb-first shift-add step, overflow is sticky
  always_comb begin
    nxt   = {1'b0, acc_q, 1'b0} + {2'b00, (b_q[MUL_B_W-1] ? a_q : '0)};
    acc_d = nxt[MUL_A_W-1:0];
    ovf_d = ovf_q | (|nxt[MUL_A_W+1:MUL_A_W]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(MUL_B_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else if (run_q) begin
      acc_q <= acc_d;
      ovf_q <= ovf_d;
      b_q   <= {b_q[MUL_B_W-2:0], 1'b0};
    end
  end

  assign rsp_o = '{done: done_q, ovf: ovf_q, prod: acc_q};

endmodule

// ===== design/spo_div.sv =====
`timescale 1ns / 1ps
module spo_div import spo_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output spo_div_rsp_t     rsp_o
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] num_q;
  logic [DEN_W-1:0] den_q, rem_q, rem_d;
  logic [DEN_W:0]   rem2;
  logic             ge;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q;

  // restoring step, one quotient bit per cycle
  always_comb begin
    rem2  = {rem_q, num_q[DIV_W-1]};
    ge    = rem2 >= {1'b0, den_q};
    rem_d = ge ? DEN_W'(rem2 - {1'b0, den_q}) : rem2[DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(DIV_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      num_q <= {num_q[DIV_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign rsp_o = '{done: done_q, quo: num_q};

endmodule

// ===== design/shaped_phase_oscillator_unit.sv =====
`timescale 1ns / 1ps
// channel   direction  beat fields (lowest bit first)
// s_axis    in         channel[3:0], mod_voltage[20:4], zero pad[23:21]
// m_axis    out        channel_out[3:0], wave_out[20:4], zero pad[23:21]
// cfg       in         cfg_index_i register index, cfg_data_i value, always ready
//
// one item at a time: each input beat takes 17 passes through the shared
// bit-serial multiplier and divider (16 passes when the octave shift saturates)
// plus a serial right shift of the frequency word by up to 63 bits.
// reset clears the channel phases through per-channel valid bits, no sweep.
// a result waiting in the output register does not block the next input beat.
module shaped_phase_oscillator_unit import spo_pkg::*; #(
  parameter int NUM_CHANNELS = SPO_NUM_CHANNELS,
  parameter int PHASE_BITS   = SPO_PHASE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,   // channel, mod_voltage
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,   // channel_out, wave_out
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SLOT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PB = PHASE_BITS;

  // configuration
  logic              lfo_q;
  logic signed [14:0] coarse_q;
  logic signed [13:0] fine_q;
  logic [23:0]       period_q;
  logic [15:0]       detune_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfo_q    <= 1'b0;
      coarse_q <= '0;
      fine_q   <= '0;
      period_q <= PERIOD_RST;
      detune_q <= DETUNE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LFO_ON: lfo_q    <= cfg_data_i[0];
        REG_COARSE: coarse_q <= cfg_data_i[14:0];
        REG_FINE:   fine_q   <= cfg_data_i[13:0];
        REG_PERIOD: period_q <= cfg_data_i[23:0];
        REG_DETUNE: detune_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // sequencer state and work registers
  spo_state_e         state_q, state_d;
  logic               launched_q, launched_d;
  logic [CH_W-1:0]    ch_q, ch_d, slot_q, slot_d;
  logic signed [MOD_W-1:0] mod_q, mod_d;
  logic signed [23:0] p_q, p_d;
  logic [31:0]        r_q, r_d;
  logic [2:0]         k_q, k_d;
  logic [63:0]        wk_q, wk_d;
  logic               sat_q, sat_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [15:0]        ph_q, ph_d;
  logic [30:0]        y2_q, y2_d, t_q, t_d;
  logic [31:0]        num_q, num_d;
  logic [1:0]         j_q, j_d;
  logic [NUM_CHANNELS-1:0] vld_q;
  logic               vld_set;
  logic               out_valid_q, out_load;
  logic [TDATA_W-1:0] out_data_q, out_data_d;

  // shared serial units
  logic               mul_start, div_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [DIV_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  spo_mul_rsp_t       mul_rsp;
  spo_div_rsp_t       div_rsp;

  spo_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b), .rsp_o(mul_rsp)
  );

  spo_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den), .rsp_o(div_rsp)
  );

  // phase store
  logic [SLOT_W-1:0] slot_idx;
  logic [PB-1:0]     ram_rdata, old_phase, phase_new, inc;
  logic              ram_we;

  assign slot_idx = SLOT_W'(slot_q);

  spo_ram #(.WIDTH(PB), .DEPTH(NUM_CHANNELS)) u_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (slot_idx),
    .wdata_i (phase_new),
    .raddr_i (slot_idx),
    .rdata_o (ram_rdata)
  );

  // derived operands
  logic [13:0]        fabs;
  logic [14:0]        cabs;
  logic [26:0]        fsum;
  logic signed [23:0] fterm, cterm, cterm_l, mod16;
  logic [7:0]         e_w;
  logic signed [8:0]  s_w;
  logic [29:0]        x_w;
  logic [16:0]        y16;
  logic [30:0]        y_w;
  logic [17:0]        lane_det;
  logic [63:0]        cyc;

  always_comb begin
    fabs     = fine_q[13] ? 14'(-fine_q) : 14'(fine_q);
    cabs     = coarse_q[14] ? 15'(-coarse_q) : 15'(coarse_q);
    fsum     = mul_rsp.prod[26:0] + 27'd512;
    fterm    = fine_q[13] ? -$signed({7'b0, fsum[26:10]}) : $signed({7'b0, fsum[26:10]});
    cterm    = coarse_q[14] ? -$signed({5'b0, div_rsp.quo[18:0]})
                            : $signed({5'b0, div_rsp.quo[18:0]});
    cterm_l  = lfo_q ? (cterm <<< 1) - LFO_DROP : cterm;
    mod16    = {{3{mod_q[MOD_W-1]}}, mod_q, 4'b0};
    e_w      = p_q[23:16];
    s_w      = 9'sd30 - $signed({e_w[7], e_w});
    x_w      = {p_q[15:0], 14'b0};
    y16      = 17'h10000 - {1'b0, ph_q};
    y_w      = {y16, 14'b0};
    lane_det = (ch_q[0] ? 18'(detune_q) : 18'd0) + (ch_q[1] ? {1'b0, detune_q, 1'b0} : 18'd0);
    inc      = wk_q[51:52-PB];
    old_phase = vld_q[slot_idx] ? ram_rdata : '0;
    phase_new = old_phase + inc;
    // clamp of cycles per sample
    if (mul_rsp.ovf || mul_rsp.prod > 64'(INC_MAX)) begin
      cyc = 64'(INC_MAX);
    end else if (mul_rsp.prod < 64'(INC_MIN)) begin
      cyc = 64'(INC_MIN);
    end else begin
      cyc = mul_rsp.prod;
    end
  end

  // output shaping
  logic signed [33:0] v0, v;
  logic signed [36:0] v5;
  logic [36:0]        vmag, vsum;
  logic signed [20:0] o_r, o_f;
  logic signed [16:0] wave;

  always_comb begin
    v0   = $signed({3'b0, t_q}) - SHAPE_OFS;
    v    = (ph_q < FLIP_Q16) ? -v0 : v0 - SHAPE_DROP;
    v5   = ($signed({{3{v[33]}}, v}) <<< 2) + $signed({{3{v[33]}}, v});
    vmag = v5[36] ? 37'(-v5) : 37'(v5);
    vsum = vmag + 37'd131072;
    o_r  = v5[36] ? -$signed({2'b0, vsum[36:18]}) : $signed({2'b0, vsum[36:18]});
    o_f  = o_r + (lfo_q ? ($signed({{7{fine_q[13]}}, fine_q}) * 21'sd5) : 21'sd0);
    if (o_f > OUT_MAX) begin
      wave = 17'(OUT_MAX);
    end else if (o_f < -OUT_MAX) begin
      wave = 17'(-OUT_MAX);
    end else begin
      wave = o_f[16:0];
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // next state and datapath control
  always_comb begin
    state_d    = state_q;
    launched_d = launched_q;
    ch_d = ch_q; slot_d = slot_q; mod_d = mod_q; p_d = p_q; r_d = r_q; k_d = k_q;
    wk_d = wk_q; sat_d = sat_q; cnt_d = cnt_q; ph_d = ph_q; y2_d = y2_q; t_d = t_q;
    num_d = num_q; j_d = j_q;
    mul_start = 1'b0; mul_a = '0; mul_b = '0;
    div_start = 1'b0; div_num = '0; div_den = '0;
    ram_we = 1'b0; vld_set = 1'b0; out_load = 1'b0;
    out_data_d = {3'b0, wave, ch_q};
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          ch_d    = s_axis_tdata[CH_W-1:0];
          slot_d  = s_axis_tdata[CH_W-1:0];
          mod_d   = s_axis_tdata[CH_W+MOD_W-1:CH_W];
          state_d = ST_SLOT;
        end
      end
      // channel modulo the channel count
      ST_SLOT: begin
        if (32'(slot_q) >= NUM_CHANNELS) begin
          slot_d = slot_q - CH_W'(NUM_CHANNELS);
        end else begin
          state_d = ST_FINE;
        end
      end
      ST_FINE: begin
        mul_a = MUL_A_W'(fabs);
        mul_b = MUL_B_W'(fabs);
        mul_start = !launched_q;
        launched_d = 1'b1;
        if (launched_q && mul_rsp.done) begin
          p_d = fterm;
          launched_d = 1'b0;
          state_d = ST_COARSE;
        end
      end
      ST_COARSE: begin
        div_num = DIV_W'({cabs, 6'b0}) + DIV_W'(1);
        div_den = DEN_COARSE;
        div_start = !launched_q;
        launched_d = 1'b1;
        if (launched_q && div_rsp.done) begin
          p_d = p_q + cterm_l + mod16;
          r_d = E5;
          k_d = '0;
          launched_d = 1'b0;
          state_d = ST_EXP;
        end
      end
      // horner steps of 2^frac
      ST_EXP: begin
        mul_a = MUL_A_W'(r_q);
        mul_b = MUL_B_W'(x_w);
        mul_start = !launched_q;
        launched_d = 1'b1;
        if (launched_q && mul_rsp.done) begin
          r_d = exp_coef(k_q) + mul_rsp.prod[61:30];
          k_d = k_q + 3'd1;
          launched_d = 1'b0;
          if (k_q == 3'd4) begin
            state_d = ST_C4;
          end
        end
      end
      ST_C4: begin
        mul_a = MUL_A_W'(r_q);
        mul_b = MUL_B_W'(C4_Q16);
        mul_start = !launched_q;
        launched_d = 1'b1;
        if (launched_q && mul_rsp.done) begin
          wk_d  = mul_rsp.prod;
          sat_d = s_w[8];
          cnt_d = '0;
          if (!s_w[8] && (s_w[7:6] != 2'b00)) begin
            wk_d = '0;
          end else if (!s_w[8]) begin
            cnt_d = s_w[5:0];
          end
          launched_d = 1'b0;
          state_d = ST_SHIFT;
        end
      end
      // octave shift one bit a cycle, then lane detune unless saturated
      ST_SHIFT: begin
        if (cnt_q != 6'd0) begin
          wk_d  = {1'b0, wk_q[63:1]};
          cnt_d = cnt_q - 6'd1;
        end else begin
          if (!sat_q) begin
            wk_d = wk_q + 64'({lane_det, 4'b0});
          end
          state_d = ST_SP;
        end
      end
      ST_SP: begin
        mul_a = wk_q;
        mul_b = MUL_B_W'(period_q);
        if (sat_q || (wk_q[63:52] != 12'd0)) begin
          wk_d = 64'(INC_MAX);
          state_d = ST_RD;
        end else begin
          mul_start = !launched_q;
          launched_d = 1'b1;
          if (launched_q && mul_rsp.done) begin
            wk_d = cyc;
            launched_d = 1'b0;
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        ram_we  = 1'b1;
        vld_set = 1'b1;
        ph_d    = phase_new[PB-1 -: 16];
        state_d = ST_Y2;
      end
      ST_Y2: begin
        mul_a = MUL_A_W'(y_w);
        mul_b = MUL_B_W'(y_w);
        mul_start = !launched_q;
        launched_d = 1'b1;
        if (launched_q && mul_rsp.done) begin
          y2_d  = mul_rsp.prod[60:30];
          num_d = DIV_W'(mul_rsp.prod[60:30]);
          j_d   = '0;
          launched_d = 1'b0;
          state_d = ST_CDIV;
        end
      end
      // cosine series, innermost term first
      ST_CDIV: begin
        div_num = num_q;
        div_den = cos_den(j_q);
        div_start = !launched_q;
        launched_d = 1'b1;
        if (launched_q && div_rsp.done) begin
          t_d = ONE_Q30[30:0] - div_rsp.quo[30:0];
          launched_d = 1'b0;
          state_d = (j_q == 2'd3) ? ST_OUT : ST_CMUL;
        end
      end
      ST_CMUL: begin
        mul_a = MUL_A_W'(y2_q);
        mul_b = MUL_B_W'(t_q);
        mul_start = !launched_q;
        launched_d = 1'b1;
        if (launched_q && mul_rsp.done) begin
          num_d = mul_rsp.prod[61:30];
          j_d   = j_q + 2'd1;
          launched_d = 1'b0;
          state_d = ST_CDIV;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launched_q  <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
      if (vld_set) begin
        vld_q[slot_idx] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ch_q <= ch_d; slot_q <= slot_d; mod_q <= mod_d; p_q <= p_d; r_q <= r_d; k_q <= k_d;
    wk_q <= wk_d; sat_q <= sat_d; cnt_q <= cnt_d; ph_q <= ph_d; y2_q <= y2_d; t_q <= t_d;
    num_q <= num_d; j_q <= j_d;
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

// ===== design/spo_checker.sv =====
`timescale 1ns / 1ps
module spo_checker import spo_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata
);

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // a result never appears right after its input beat
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early");

  // output voltage saturated
  a_wave_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[20:4]) <= 17'sd49152) &&
                      ($signed(m_axis_tdata[20:4]) >= -17'sd49152))
    else $error("wave beyond limit");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");

endmodule

bind shaped_phase_oscillator_unit spo_checker u_spo_checker (.*);

// ===== test/tb_wave_checker.sv =====
`timescale 1ns / 1ps
module tb_wave_checker import spo_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  input  logic                  s_ready_i,
  input  logic [TDATA_W-1:0]    s_data_i,
  input  logic                  m_valid_i,
  input  logic                  m_ready_i,
  input  logic [TDATA_W-1:0]    m_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_cnt_o,
  output int                    pending_o
);

  typedef struct {
    logic [CH_W-1:0]   ch;
    logic [WAVE_W-1:0] wave;
  } wave_beat_t;

  wave_beat_t        wave_due[$];
  logic [31:0]       phase_acc [SPO_NUM_CHANNELS];
  logic              lfo_on;
  longint            coarse_pitch;
  longint            fine_knob;
  longint unsigned   sample_period;
  longint unsigned   lane_detune;

  assign pending_o = wave_due.size();

  // rounding division, half away from zero
  function automatic longint div_round(input longint n, input longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  // 2^frac in q30, frac in q16
  function automatic longint unsigned pow2_frac(input longint unsigned frac16);
    longint unsigned x, r;
    x = frac16 << 14;
    r = 64'(E5);
    r = 64'(E4) + ((r * x) >> 30);
    r = 64'(E3) + ((r * x) >> 30);
    r = 64'(E2) + ((r * x) >> 30);
    r = 64'(E1) + ((r * x) >> 30);
    return 64'(ONE_Q30) + ((r * x) >> 30);
  endfunction

  // cosine in q30 of a q16 angle
  function automatic longint unsigned cos_series(input longint unsigned y16);
    longint unsigned y, y2, one, t;
    y   = y16 << 14;
    y2  = (y * y) >> 30;
    one = 64'(ONE_Q30);
    t = one - y2 / 56;
    t = one - ((y2 * t) >> 30) / 30;
    t = one - ((y2 * t) >> 30) / 12;
    t = one - ((y2 * t) >> 30) / 2;
    return t;
  endfunction

  // advance one channel phase and form its output voltage
  function automatic logic [WAVE_W-1:0] next_wave(input logic [CH_W-1:0] ch,
                                                  input logic [MOD_W-1:0] mod_raw);
    longint          p, e, fabs, s, v, o, modv;
    longint unsigned f46, freq, hi, lo, cyc, inc, ph;
    logic            sat;
    modv = $signed(mod_raw);
    p = div_round(coarse_pitch * 64, 3);
    if (lfo_on) p = 2 * p - 5 * 65536;
    fabs = (fine_knob < 0) ? -fine_knob : fine_knob;
    p += div_round(fine_knob * fabs, 1024);
    p += modv * 16;
    e = p >>> 16;
    f46 = 64'(C4_Q16) * pow2_frac(longint'(p[15:0]));
    s = 30 - e;
    sat = 1'b0;
    freq = 0;
    if (s < 0) sat = 1'b1;
    else if (s < 64) freq = f46 >> s;
    if (!sat) freq += longint'(ch[1:0]) * lane_detune * 16;
    // cycles per sample in q52, clamped
    hi = freq >> 24;
    lo = freq & 64'hFFFFFF;
    if (sat || hi >= (64'd1 << 28) || hi * sample_period >= (64'd1 << 28)) begin
      cyc = 64'(INC_MAX);
    end else begin
      cyc = ((hi * sample_period) << 24) + lo * sample_period;
      if (cyc > 64'(INC_MAX)) cyc = 64'(INC_MAX);
    end
    if (cyc < 64'(INC_MIN)) cyc = 64'(INC_MIN);
    inc = cyc >> (52 - SPO_PHASE_BITS);
    phase_acc[ch] = phase_acc[ch] + 32'(inc);
    ph = longint'(phase_acc[ch] >> 16);
    // shaped pulse with sign flip near phase zero
    v = longint'(cos_series(65536 - ph)) - longint'(SHAPE_OFS);
    if (ph < longint'(FLIP_Q16)) v = -v;
    else v -= longint'(SHAPE_DROP);
    o = div_round(v * 5, 262144);
    if (lfo_on) o += fine_knob * 5;
    if (o > 49152) o = 49152;
    if (o < -49152) o = -49152;
    return o[WAVE_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wave_beat_t got, want;
    if (!rst_ni) begin
      foreach (phase_acc[i]) phase_acc[i] = '0;
      lfo_on = 1'b0;
      coarse_pitch = 0;
      fine_knob = 0;
      sample_period = 64'(PERIOD_RST);
      lane_detune = 64'(DETUNE_RST);
      wave_due.delete();
      fail_cnt_o = 0;
    end else begin
      // result beats against the oldest prediction
      if (m_valid_i && m_ready_i) begin
        got.ch   = m_data_i[CH_W-1:0];
        got.wave = m_data_i[CH_W +: WAVE_W];
        if (wave_due.size() == 0) begin
          $error("unexpected result beat: channel_out %0d wave_out %0d",
                 got.ch, $signed(got.wave));
          fail_cnt_o++;
        end else begin
          want = wave_due.pop_front();
          if (got.ch !== want.ch) begin
            $error("channel_out expected %0d actual %0d", want.ch, got.ch);
            fail_cnt_o++;
          end
          if (got.wave !== want.wave) begin
            $error("wave_out expected %0d actual %0d", $signed(want.wave),
                   $signed(got.wave));
            fail_cnt_o++;
          end
        end
      end
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_LFO_ON: lfo_on = cfg_data_i[0];
          REG_COARSE: coarse_pitch = $signed(cfg_data_i[14:0]);
          REG_FINE:   fine_knob = $signed(cfg_data_i[13:0]);
          REG_PERIOD: sample_period = 64'(cfg_data_i);
          REG_DETUNE: lane_detune = 64'(cfg_data_i[15:0]);
          default: ;
        endcase
      end
      // input beats
      if (s_valid_i && s_ready_i) begin
        want.ch   = s_data_i[CH_W-1:0];
        want.wave = next_wave(s_data_i[CH_W-1:0], s_data_i[CH_W +: MOD_W]);
        wave_due.push_back(want);
      end
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top import spo_pkg::*;;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 700;
  localparam int HOLD_LEN   = 3000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int fail_cnt, pending, idle_cycles, burst_left;
  bit hold_req = 1'b0;

  always #4 clk_i = ~clk_i;

  shaped_phase_oscillator_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  tb_wave_checker chk (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // receiver: stall pattern picked at random and changed now and then, plus one long hold-off
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(50, 400);
      end
      left--;
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 1);
        2: m_axis_tready <= ($urandom_range(0, 5) == 0);
        default: m_axis_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one register beat, valid left high for the caller to drop
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
  endtask

  // writes only once the block has drained
  task automatic set_config(input logic lfo, input logic [14:0] coarse,
                            input logic [13:0] fine, input logic [23:0] period,
                            input logic [15:0] detune);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    reg_write(REG_LFO_ON, 24'(lfo));
    reg_write(REG_COARSE, 24'(coarse));
    reg_write(REG_FINE, 24'(fine));
    reg_write(REG_PERIOD, period);
    reg_write(REG_DETUNE, 24'(detune));
    reg_write(3'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), 24'($urandom));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one input beat, sent in bursts with random gaps
  task automatic send_mod(input logic [CH_W-1:0] ch, input logic [MOD_W-1:0] mod);
    if (burst_left == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(0, 900)) @(negedge clk_i);
      else repeat ($urandom_range(0, 40)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, mod, ch};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  function automatic logic [MOD_W-1:0] rand_mod();
    case ($urandom_range(0, 5))
      0: return 17'($urandom);
      1: return ($urandom_range(0, 1) == 1) ? 17'(40960) : 17'(-40960);
      2: return 17'($signed($urandom_range(0, 8192)) - 4096);
      default: return 17'($signed($urandom_range(0, 81920)) - 40960);
    endcase
  endfunction

  initial begin
    logic [14:0] coarse;
    logic [13:0] fine;
    logic [23:0] period;
    logic [15:0] detune;
    burst_left = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: every channel, modulation extremes, out-of-range raw values
    for (int c = 0; c < 16; c++) send_mod(4'(c), '0);
    send_mod(4'd0, 17'(40960));
    send_mod(4'd3, 17'(-40960));
    send_mod(4'd5, 17'h0FFFF);
    send_mod(4'd6, 17'h10000);
    send_mod(4'd7, 17'h1FFFF);
    send_mod(4'd15, 17'(20000));

    // extreme settings: high pitch longest period, then lfo with lowest pitch
    set_config(1'b0, 15'(13824), 14'(4096), 24'hFFFFFF, 16'hFFFF);
    for (int c = 0; c < 6; c++) send_mod(4'(c), 17'(40960));
    set_config(1'b1, 15'(-13824), 14'(-4096), 24'd0, 16'd0);
    for (int c = 0; c < 6; c++) send_mod(4'(c), 17'(-40960));

    // random phases, with raw out-of-range register values now and then
    for (int ph = 0; ph < 10; ph++) begin
      coarse = ($urandom_range(0, 4) == 0) ? 15'($urandom)
                                           : 15'($signed($urandom_range(0, 27648)) - 13824);
      fine   = ($urandom_range(0, 4) == 0) ? 14'($urandom)
                                           : 14'($signed($urandom_range(0, 8192)) - 4096);
      case ($urandom_range(0, 3))
        0: period = 24'd1;
        1: period = 24'hFFFFFF;
        default: period = 24'($urandom_range(1, 24'hFFFFFF));
      endcase
      detune = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      set_config(1'($urandom), coarse, fine, period, detune);
      for (int i = 0; i < 95; i++) begin
        if (ph == 4 && i == 10) hold_req = 1'b1;
        send_mod(4'($urandom), rand_mod());
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/spo_pkg.sv
design/spo_ram.sv
design/spo_mul.sv
design/spo_div.sv
design/shaped_phase_oscillator_unit.sv
design/spo_checker.sv
test/tb_wave_checker.sv
test/tb_top.sv
